/* design/mpfb_pkg.sv */
// Shared constants, types and helpers for the page-mode frame buffer flush unit.
`timescale 1ns / 1ps

package mpfb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W = $clog2(STORE_BYTES);

  localparam int X_W   = 7;
  localparam int Y_W   = 6;
  localparam int WID_W = 8;
  localparam int HGT_W = 7;

  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [2:0] ROW_IN_PAGE   = 3'h7;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_TICK
  } state_t;

  typedef enum logic [2:0] {
    CI_COL_CMD,
    CI_COL_FIRST,
    CI_COL_LAST,
    CI_PAGE_CMD,
    CI_PAGE_FIRST,
    CI_PAGE_LAST,
    CI_DATA
  } cmd_idx_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(int'(page) * PANEL_WIDTH + int'(col));
  endfunction

  // rows lo..hi of one page set
  function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i] = (3'(i) >= lo) && (3'(i) <= hi);
    end
    return m;
  endfunction

endpackage

/* design/mono_page_framebuffer_flush_unit.sv */
// Top level: request decode, frame store, two-entry result queue.
//
//  channel  dir  tdata                                   tuser       tlast
//  in_      in   pixel_on,x_origin,y_origin,width,height  req_type    -
//  out_     out  out_byte                                 is_data     last_byte
//
// Work: a flush start or command-byte tick needs no store access; a pixel write
// or data-byte tick does one store read with registered data, then modify/write
// or emit; a rectangle fill reads one store byte per cycle with write-back
// overlapped on the next read. Reset: a clearing pass zeroes the 1024-byte store,
// one byte a cycle, and no request is taken until it is done. Results queue in
// two entries, so a request is taken while one result still waits on out_tready.
`timescale 1ns / 1ps

module mono_page_framebuffer_flush_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_on, x_origin[6:0], y_origin[5:0],
                                  // rect_width[7:0], rect_height[6:0], zero pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tuser,  // is_data
  output logic        out_tlast   // last_byte
);

  mpfb_pkg::res_push_t res_push;
  mpfb_pkg::mem_wr_t   mem_wr;
  mpfb_pkg::mem_rd_t   mem_rd;
  logic [7:0]          rd_data;
  logic                res_room;

  mpfb_pkg::res_t      q_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;

  assign pop      = out_tvalid && out_tready;
  assign res_room = (cnt_r != 2'd2);

  mpfb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (mpfb_pkg::req_t'(in_tuser)),
    .pixel_on    (in_tdata[0]),
    .x_origin    (in_tdata[7:1]),
    .y_origin    (in_tdata[13:8]),
    .rect_width  (in_tdata[21:14]),
    .rect_height (in_tdata[28:22]),
    .res_room    (res_room),
    .res_push    (res_push),
    .mem_wr      (mem_wr),
    .mem_rd      (mem_rd),
    .rd_data     (rd_data)
  );

  mpfb_store u_store (
    .clk     (clk),
    .mem_wr  (mem_wr),
    .mem_rd  (mem_rd),
    .rd_data (rd_data)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push.valid && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!res_push.valid && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_push.valid) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.valid) begin
      q_r[wp_r] <= res_push.res;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[rp_r].data;
  assign out_tuser  = q_r[rp_r].is_data;
  assign out_tlast  = q_r[rp_r].last;

endmodule

/* design/mpfb_store.sv */
// Frame store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mpfb_store (
  input  logic                  clk,
  input  mpfb_pkg::mem_wr_t     mem_wr,
  input  mpfb_pkg::mem_rd_t     mem_rd,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [mpfb_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd.en) begin
      rd_data <= mem[mem_rd.addr];
    end
  end

endmodule

/* design/mpfb_seq.sv */
// Request sequencer: clearing pass, pixel and fill read-modify-write, flush stream walk.
`timescale 1ns / 1ps

module mpfb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mpfb_pkg::req_t                req_type,
  input  logic                          pixel_on,
  input  logic [mpfb_pkg::X_W-1:0]      x_origin,
  input  logic [mpfb_pkg::Y_W-1:0]      y_origin,
  input  logic [mpfb_pkg::WID_W-1:0]    rect_width,
  input  logic [mpfb_pkg::HGT_W-1:0]    rect_height,
  input  logic                          res_room,
  output mpfb_pkg::res_push_t           res_push,
  output mpfb_pkg::mem_wr_t             mem_wr,
  output mpfb_pkg::mem_rd_t             mem_rd,
  input  logic [7:0]                    rd_data
);

  localparam int XS_W = mpfb_pkg::X_W + 2;
  localparam int YS_W = mpfb_pkg::Y_W + 2;
  localparam int CW   = mpfb_pkg::COL_W;
  localparam int PW   = mpfb_pkg::PAGE_W;
  localparam int AW   = mpfb_pkg::ADDR_W;

  mpfb_pkg::state_t   state_r, state_nxt;
  mpfb_pkg::cmd_idx_t cmd_idx_r, cmd_idx_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               fl_active_r, fl_active_nxt;
  logic [CW-1:0]      win_cf_r, win_cf_nxt, win_cl_r, win_cl_nxt;
  logic [PW-1:0]      win_pf_r, win_pf_nxt, win_pl_r, win_pl_nxt;
  logic [PW-1:0]      cur_page_r, cur_page_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;

  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic [7:0]         wr_mask_r, wr_mask_nxt;
  logic               wr_on_r, wr_on_nxt;

  logic               f_on_r, f_on_nxt;
  logic [PW-1:0]      f_page_r, f_page_nxt, f_pf_r, f_pf_nxt, f_pl_r, f_pl_nxt;
  logic [CW-1:0]      f_col_r, f_col_nxt, f_cf_r, f_cf_nxt, f_cl_r, f_cl_nxt;
  logic [2:0]         f_rlo_r, f_rlo_nxt, f_rhi_r, f_rhi_nxt;

  logic               accept;
  logic [XS_W-1:0]    x_sum, x_end;
  logic [YS_W-1:0]    y_sum, y_end;
  logic               span_ok, px_ok;
  logic [CW-1:0]      col_first, col_last;
  logic [PW-1:0]      page_first, page_last;
  logic [2:0]         fill_lo, fill_hi;
  logic               tick_last, fill_last;
  logic [7:0]         cmd_byte;

  assign in_ready = (state_r == mpfb_pkg::ST_IDLE) && res_room;
  assign accept   = in_valid && in_ready;

  // clipping of the request span
  always_comb begin
    x_sum = XS_W'(x_origin) + XS_W'(rect_width) - XS_W'(1);
    x_end = (x_sum > XS_W'(mpfb_pkg::PANEL_WIDTH - 1)) ?
            XS_W'(mpfb_pkg::PANEL_WIDTH - 1) : x_sum;
    y_sum = YS_W'(y_origin) + YS_W'(rect_height) - YS_W'(1);
    y_end = (y_sum > YS_W'(mpfb_pkg::PANEL_HEIGHT - 1)) ?
            YS_W'(mpfb_pkg::PANEL_HEIGHT - 1) : y_sum;
    px_ok = (XS_W'(x_origin) < XS_W'(mpfb_pkg::PANEL_WIDTH)) &&
            (YS_W'(y_origin) < YS_W'(mpfb_pkg::PANEL_HEIGHT));
    span_ok = (rect_width != '0) && (rect_height != '0) && px_ok;
    col_first  = CW'(XS_W'(mpfb_pkg::PANEL_WIDTH - 1) - x_end);
    col_last   = CW'(XS_W'(mpfb_pkg::PANEL_WIDTH - 1) - XS_W'(x_origin));
    page_first = PW'(y_origin >> 3);
    page_last  = PW'(y_end >> 3);
  end

  always_comb begin
    fill_lo   = (f_page_r == f_pf_r) ? f_rlo_r : 3'd0;
    fill_hi   = (f_page_r == f_pl_r) ? f_rhi_r : mpfb_pkg::ROW_IN_PAGE;
    fill_last = (f_page_r == f_pl_r) && (f_col_r == f_cl_r);
    tick_last = (cur_page_r == win_pl_r) && (cur_col_r == win_cl_r);
  end

  always_comb begin
    case (cmd_idx_r)
      mpfb_pkg::CI_COL_CMD:    cmd_byte = mpfb_pkg::CMD_COL_ADDR;
      mpfb_pkg::CI_COL_FIRST:  cmd_byte = 8'(win_cf_r);
      mpfb_pkg::CI_COL_LAST:   cmd_byte = 8'(win_cl_r);
      mpfb_pkg::CI_PAGE_CMD:   cmd_byte = mpfb_pkg::CMD_PAGE_ADDR;
      mpfb_pkg::CI_PAGE_FIRST: cmd_byte = 8'(win_pf_r);
      mpfb_pkg::CI_PAGE_LAST:  cmd_byte = 8'(win_pl_r);
      default:                 cmd_byte = 8'h00;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpfb_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(mpfb_pkg::STORE_BYTES - 1)) begin
          state_nxt = mpfb_pkg::ST_IDLE;
        end
      end
      mpfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type)
            mpfb_pkg::REQ_PIXEL: if (px_ok) state_nxt = mpfb_pkg::ST_DRAIN;
            mpfb_pkg::REQ_FILL:  if (span_ok) state_nxt = mpfb_pkg::ST_FILL;
            mpfb_pkg::REQ_TICK: begin
              if (fl_active_r && (cmd_idx_r == mpfb_pkg::CI_DATA)) begin
                state_nxt = mpfb_pkg::ST_TICK;
              end
            end
            default: state_nxt = mpfb_pkg::ST_IDLE;
          endcase
        end
      end
      mpfb_pkg::ST_FILL:  if (fill_last) state_nxt = mpfb_pkg::ST_DRAIN;
      mpfb_pkg::ST_DRAIN: state_nxt = mpfb_pkg::ST_IDLE;
      mpfb_pkg::ST_TICK:  state_nxt = mpfb_pkg::ST_IDLE;
      default:            state_nxt = mpfb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_idx_nxt   = cmd_idx_r;
    clr_cnt_nxt   = clr_cnt_r;
    fl_active_nxt = fl_active_r;
    win_cf_nxt    = win_cf_r;
    win_cl_nxt    = win_cl_r;
    win_pf_nxt    = win_pf_r;
    win_pl_nxt    = win_pl_r;
    cur_page_nxt  = cur_page_r;
    cur_col_nxt   = cur_col_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    wr_on_nxt     = wr_on_r;
    f_on_nxt      = f_on_r;
    f_page_nxt    = f_page_r;
    f_pf_nxt      = f_pf_r;
    f_pl_nxt      = f_pl_r;
    f_col_nxt     = f_col_r;
    f_cf_nxt      = f_cf_r;
    f_cl_nxt      = f_cl_r;
    f_rlo_nxt     = f_rlo_r;
    f_rhi_nxt     = f_rhi_r;
    mem_rd        = '0;
    res_push      = '0;

    if (state_r == mpfb_pkg::ST_CLEAR) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_cnt_r;
      mem_wr.data = 8'h00;
    end else begin
      mem_wr.en   = wr_pend_r;
      mem_wr.addr = wr_addr_r;
      mem_wr.data = wr_on_r ? (rd_data | wr_mask_r) : (rd_data & ~wr_mask_r);
    end

    case (state_r)
      mpfb_pkg::ST_CLEAR: clr_cnt_nxt = clr_cnt_r + AW'(1);
      mpfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type)
            mpfb_pkg::REQ_PIXEL: begin
              if (px_ok) begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = mpfb_pkg::store_addr(page_first, col_last);
                wr_pend_nxt = 1'b1;
                wr_addr_nxt = mpfb_pkg::store_addr(page_first, col_last);
                wr_mask_nxt = 8'b1 << y_origin[2:0];
                wr_on_nxt   = pixel_on;
              end
            end
            mpfb_pkg::REQ_FILL: begin
              if (span_ok) begin
                f_on_nxt   = pixel_on;
                f_page_nxt = page_first;
                f_pf_nxt   = page_first;
                f_pl_nxt   = page_last;
                f_col_nxt  = col_first;
                f_cf_nxt   = col_first;
                f_cl_nxt   = col_last;
                f_rlo_nxt  = y_origin[2:0];
                f_rhi_nxt  = y_end[2:0];
              end
            end
            mpfb_pkg::REQ_FLUSH: begin
              if (span_ok) begin
                win_cf_nxt    = col_first;
                win_cl_nxt    = col_last;
                win_pf_nxt    = page_first;
                win_pl_nxt    = page_last;
                cur_page_nxt  = page_first;
                cur_col_nxt   = col_first;
                cmd_idx_nxt   = mpfb_pkg::CI_COL_CMD;
                fl_active_nxt = 1'b1;
              end
            end
            default: begin
              if (fl_active_r) begin
                if (cmd_idx_r != mpfb_pkg::CI_DATA) begin
                  res_push.valid       = 1'b1;
                  res_push.res.data    = cmd_byte;
                  res_push.res.is_data = 1'b0;
                  res_push.res.last    = 1'b0;
                  cmd_idx_nxt          = mpfb_pkg::cmd_idx_t'(cmd_idx_r + 3'd1);
                end else begin
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = mpfb_pkg::store_addr(cur_page_r, cur_col_r);
                end
              end
            end
          endcase
        end
      end
      mpfb_pkg::ST_FILL: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = mpfb_pkg::store_addr(f_page_r, f_col_r);
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = mpfb_pkg::store_addr(f_page_r, f_col_r);
        wr_mask_nxt = mpfb_pkg::page_mask(fill_lo, fill_hi);
        wr_on_nxt   = f_on_r;
        if (f_col_r == f_cl_r) begin
          f_col_nxt  = f_cf_r;
          f_page_nxt = f_page_r + PW'(1);
        end else begin
          f_col_nxt = f_col_r + CW'(1);
        end
      end
      mpfb_pkg::ST_TICK: begin
        res_push.valid       = 1'b1;
        res_push.res.data    = rd_data;
        res_push.res.is_data = 1'b1;
        res_push.res.last    = tick_last;
        if (tick_last) begin
          fl_active_nxt = 1'b0;
        end else if (cur_col_r == win_cl_r) begin
          cur_col_nxt  = win_cf_r;
          cur_page_nxt = cur_page_r + PW'(1);
        end else begin
          cur_col_nxt = cur_col_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpfb_pkg::ST_CLEAR;
      cmd_idx_r   <= mpfb_pkg::CI_COL_CMD;
      clr_cnt_r   <= '0;
      fl_active_r <= 1'b0;
      win_cf_r    <= '0;
      win_cl_r    <= '0;
      win_pf_r    <= '0;
      win_pl_r    <= '0;
      cur_page_r  <= '0;
      cur_col_r   <= '0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_idx_r   <= cmd_idx_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fl_active_r <= fl_active_nxt;
      win_cf_r    <= win_cf_nxt;
      win_cl_r    <= win_cl_nxt;
      win_pf_r    <= win_pf_nxt;
      win_pl_r    <= win_pl_nxt;
      cur_page_r  <= cur_page_nxt;
      cur_col_r   <= cur_col_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    wr_mask_r <= wr_mask_nxt;
    wr_on_r   <= wr_on_nxt;
    f_on_r    <= f_on_nxt;
    f_page_r  <= f_page_nxt;
    f_pf_r    <= f_pf_nxt;
    f_pl_r    <= f_pl_nxt;
    f_col_r   <= f_col_nxt;
    f_cf_r    <= f_cf_nxt;
    f_cl_r    <= f_cl_nxt;
    f_rlo_r   <= f_rlo_nxt;
    f_rhi_r   <= f_rhi_nxt;
  end

endmodule

/* tb/tb_mono_page_framebuffer_flush_unit.sv */
// Self-checking testbench for the page-mode frame buffer flush unit.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_flush_unit;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 1100;
  localparam int ITEM_TARGET = 800;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BYTE} chk_t;

  typedef struct packed {
    mpfb_pkg::req_t             req;
    logic                       pix_on;
    logic [mpfb_pkg::X_W-1:0]   x;
    logic [mpfb_pkg::Y_W-1:0]   y;
    logic [mpfb_pkg::WID_W-1:0] w;
    logic [mpfb_pkg::HGT_W-1:0] h;
  } fb_req_t;

  typedef struct packed {
    fb_req_t        rq;
    chk_t           chk;
    mpfb_pkg::res_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = mpfb_pkg::REQ_PIXEL;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  mono_page_framebuffer_flush_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // shadow frame and flush walker
  logic [7:0]         shadow_fb [mpfb_pkg::STORE_BYTES];
  bit                 fl_active;
  mpfb_pkg::cmd_idx_t fl_step;
  int                 win_c0, win_c1, win_p0, win_p1, cur_p, cur_c;

  mpfb_pkg::res_t stream_q [$];
  dir_row_t       dir_tab [$];
  int             err_cnt, useful_cnt, n_bytes, n_streams;
  int             n_req [4];
  bit             no_idle, long_hold_go, long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic fb_req_t mk_req(mpfb_pkg::req_t rq, int on, int x, int y, int w, int h);
    fb_req_t r;
    r.req    = rq;
    r.pix_on = on[0];
    r.x      = x[mpfb_pkg::X_W-1:0];
    r.y      = y[mpfb_pkg::Y_W-1:0];
    r.w      = w[mpfb_pkg::WID_W-1:0];
    r.h      = h[mpfb_pkg::HGT_W-1:0];
    return r;
  endfunction

  function automatic fb_req_t rand_req(mpfb_pkg::req_t rq, int big);
    if (big)
      return mk_req(rq, $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 63),
                    $urandom_range(0, 255), $urandom_range(0, 127));
    return mk_req(rq, $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 63),
                  $urandom_range(1, 20), $urandom_range(1, 16));
  endfunction

  function automatic fb_req_t rand_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return rand_req(mpfb_pkg::REQ_FLUSH, 0);
    if (r < 95) return rand_req(mpfb_pkg::REQ_FLUSH, 1);
    return mk_req(mpfb_pkg::REQ_FLUSH, 0, 0, 0, mpfb_pkg::PANEL_WIDTH, mpfb_pkg::PANEL_HEIGHT);
  endfunction

  function automatic bit clip_span(input int org, input int len, input int lim, output int e);
    if (len == 0 || org >= lim) return 1'b0;
    e = org + len - 1;
    if (e > lim - 1) e = lim - 1;
    return 1'b1;
  endfunction

  function automatic void shadow_pixel(logic on, int x, int y);
    int idx;
    if (x >= mpfb_pkg::PANEL_WIDTH || y >= mpfb_pkg::PANEL_HEIGHT) return;
    idx = (y >> 3) * mpfb_pkg::PANEL_WIDTH + (mpfb_pkg::PANEL_WIDTH - 1 - x);
    shadow_fb[idx][y & mpfb_pkg::ROW_IN_PAGE] = on;
  endfunction

  // returns 1 for every pixel write and for any fill, flush or tick that is not dropped
  function automatic bit shadow_request(input fb_req_t rq, output bit has_res,
                                        output mpfb_pkg::res_t res);
    int xe, ye, r, c;
    has_res = 1'b0;
    res     = '0;
    case (rq.req)
      mpfb_pkg::REQ_PIXEL: begin
        shadow_pixel(rq.pix_on, rq.x, rq.y);
        return 1'b1;
      end
      mpfb_pkg::REQ_FILL: begin
        if (!clip_span(rq.x, rq.w, mpfb_pkg::PANEL_WIDTH, xe) ||
            !clip_span(rq.y, rq.h, mpfb_pkg::PANEL_HEIGHT, ye))
          return 1'b0;
        for (r = int'(rq.y); r <= ye; r++)
          for (c = int'(rq.x); c <= xe; c++)
            shadow_pixel(rq.pix_on, c, r);
        return 1'b1;
      end
      mpfb_pkg::REQ_FLUSH: begin
        if (!clip_span(rq.x, rq.w, mpfb_pkg::PANEL_WIDTH, xe) ||
            !clip_span(rq.y, rq.h, mpfb_pkg::PANEL_HEIGHT, ye))
          return 1'b0;
        win_c0    = mpfb_pkg::PANEL_WIDTH - 1 - xe;
        win_c1    = mpfb_pkg::PANEL_WIDTH - 1 - int'(rq.x);
        win_p0    = int'(rq.y) >> 3;
        win_p1    = ye >> 3;
        cur_p     = win_p0;
        cur_c     = win_c0;
        fl_step   = mpfb_pkg::CI_COL_CMD;
        fl_active = 1'b1;
        return 1'b1;
      end
      default: begin
        if (!fl_active) return 1'b0;
        has_res = 1'b1;
        if (fl_step != mpfb_pkg::CI_DATA) begin
          case (fl_step)
            mpfb_pkg::CI_COL_CMD:    res.data = mpfb_pkg::CMD_COL_ADDR;
            mpfb_pkg::CI_COL_FIRST:  res.data = 8'(win_c0);
            mpfb_pkg::CI_COL_LAST:   res.data = 8'(win_c1);
            mpfb_pkg::CI_PAGE_CMD:   res.data = mpfb_pkg::CMD_PAGE_ADDR;
            mpfb_pkg::CI_PAGE_FIRST: res.data = 8'(win_p0);
            default:                 res.data = 8'(win_p1);
          endcase
          fl_step = mpfb_pkg::cmd_idx_t'(fl_step + 3'd1);
        end else begin
          res.data    = shadow_fb[cur_p * mpfb_pkg::PANEL_WIDTH + cur_c];
          res.is_data = 1'b1;
          res.last    = (cur_p == win_p1) && (cur_c == win_c1);
          if (res.last) begin
            fl_active = 1'b0;
          end else if (cur_c == win_c1) begin
            cur_c = win_c0;
            cur_p++;
          end else begin
            cur_c++;
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // leaves in_tvalid high when the next request follows at once
  task automatic send_req(input fb_req_t rq, input chk_t chk, input mpfb_pkg::res_t want);
    bit             has_res, eff;
    mpfb_pkg::res_t got;
    int             gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, rq.h, rq.w, rq.y, rq.x, rq.pix_on};
    in_tuser  <= rq.req;
    do @(posedge clk); while (!(rst_n && in_tready === 1'b1));
    eff = shadow_request(rq, has_res, got);
    if (chk == CHK_BYTE) stream_q.push_back(want);
    else if (chk == CHK_MODEL && has_res) stream_q.push_back(got);
    if (eff) useful_cnt++;
    n_req[rq.req]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rand(input fb_req_t rq);
    send_req(rq, CHK_MODEL, '0);
  endtask

  task automatic add_row(mpfb_pkg::req_t rq, int on, int x, int y, int w, int h, chk_t chk,
                         logic [7:0] d, logic isd, logic lst);
    dir_row_t row;
    row.rq           = mk_req(rq, on, x, y, w, h);
    row.chk          = chk;
    row.want.data    = d;
    row.want.is_data = isd;
    row.want.last    = lst;
    dir_tab.push_back(row);
  endtask

  // random drains stop at the item target
  task automatic drain_flush(input bit pixels);
    while (fl_active && (!pixels || useful_cnt < ITEM_TARGET)) begin
      if (pixels && $urandom_range(0, 9) == 0) send_rand(rand_req(mpfb_pkg::REQ_PIXEL, 1));
      else send_rand(rand_req(mpfb_pkg::REQ_TICK, 1));
    end
  endtask

  // result side
  initial begin : sink
    int             stall, hold_left;
    mpfb_pkg::res_t want;
    stall     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        n_bytes++;
        if (out_tlast) n_streams++;
        if (stream_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte, actual data=%02h is_data=%0b last=%0b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = stream_q.pop_front();
          if (out_tdata !== want.data || out_tuser !== want.is_data ||
              out_tlast !== want.last) begin
            err_cnt++;
            $display("%0t: mismatch, expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                     $time, want.data, want.is_data, want.last,
                     out_tdata, out_tuser, out_tlast);
          end
        end
      end
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stim
    int  r, n, k;
    bit  hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    fl_active = 1'b0;
    fl_step   = mpfb_pkg::CI_COL_CMD;
    win_c0 = 0; win_c1 = 0; win_p0 = 0; win_p1 = 0; cur_p = 0; cur_c = 0;

    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_NONE,  8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_PIXEL, 1,   0,  0,   0,   0, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_PIXEL, 1, 127, 63,   0,   0, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_PIXEL, 0,   0,  0,   0,   0, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FILL,  1, 120, 56, 255, 127, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FILL,  1,   0,  0,   0,  64, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FILL,  1,   0,  0, 128,   0, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FLUSH, 0,   0,  0,   0,  64, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_NONE,  8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FLUSH, 0, 126, 56,   2,   8, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK, 0, 0, 0, 0, 0, CHK_BYTE, mpfb_pkg::CMD_COL_ADDR, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  1, 127, 63, 255, 127, CHK_BYTE,  8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'h01, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK, 0, 0, 0, 0, 0, CHK_BYTE, mpfb_pkg::CMD_PAGE_ADDR, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'h07, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'h07, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'hFF, 1'b1, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'hFF, 1'b1, 1'b1);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_NONE,  8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FLUSH, 0,   0,  0, 128,  64, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK, 0, 0, 0, 0, 0, CHK_BYTE, mpfb_pkg::CMD_COL_ADDR, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FLUSH, 0, 127, 63,   1,   1, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK, 0, 0, 0, 0, 0, CHK_BYTE, mpfb_pkg::CMD_COL_ADDR, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_FLUSH, 0,   5,  5,  10,   0, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfb_pkg::REQ_TICK,  0,   0,  0,   0,   0, CHK_BYTE,  8'h00, 1'b0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].chk, dir_tab[i].want);

    while (useful_cnt < ITEM_TARGET || !hold_done || !pause_done) begin
      no_idle = ($urandom_range(0, 9) == 0);
      if (!hold_done && useful_cnt >= 200) begin
        // receiver stalls while a long stream backs up into the input
        hold_done = 1'b1;
        no_idle   = 1'b1;
        send_rand(mk_req(mpfb_pkg::REQ_FLUSH, 0, 0, 0, 32, 16));
        long_hold_go = 1'b1;
        drain_flush(1'b0);
      end else if (!pause_done && useful_cnt >= 500) begin
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        while (stream_q.size() != 0) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) send_rand(rand_req(mpfb_pkg::REQ_PIXEL, 1));
            else send_rand(rand_req(mpfb_pkg::REQ_FILL, $urandom_range(0, 99) < 15));
          end
        end else if (r < 75) begin
          send_rand(rand_window());
          drain_flush(1'b1);
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) send_rand(rand_req(mpfb_pkg::REQ_TICK, 1));
        end else if (r < 88) begin
          // stream cut short by a later flush start
          send_rand(rand_window());
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) send_rand(rand_req(mpfb_pkg::REQ_TICK, 1));
        end else begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++)
            send_rand(rand_req(mpfb_pkg::req_t'($urandom_range(0, 3)), 1));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests: %0d pixel writes, %0d fills, %0d flush starts, %0d ticks.",
             n_req[0] + n_req[1] + n_req[2] + n_req[3], n_req[mpfb_pkg::REQ_PIXEL],
             n_req[mpfb_pkg::REQ_FILL], n_req[mpfb_pkg::REQ_FLUSH],
             n_req[mpfb_pkg::REQ_TICK]);
    $display("Checked %0d stream bytes, %0d flush streams run to the final byte.",
             n_bytes, n_streams);
    if (err_cnt == 0 && stream_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
